// ===== design/apes_pkg.sv =====
// shared types, constants and helper functions of the pitch-plane flight step
`timescale 1ns / 1ps

package apes_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int POSITION_BITS = 48;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  // configuration register indexes
  localparam logic [2:0] REG_STEP_TIME  = 3'd0;
  localparam logic [2:0] REG_MASS_RECIP = 3'd1;
  localparam logic [2:0] REG_DENSITY    = 3'd2;
  localparam logic [2:0] REG_WING_AREA  = 3'd3;
  localparam logic [2:0] REG_ELEVATOR   = 3'd4;
  localparam logic [2:0] REG_ROLL       = 3'd5;
  localparam logic [2:0] REG_YAW        = 3'd6;

  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
  localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;

  localparam logic signed [63:0] BIG_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] COEF_LIM = 64'sd1099511627775;
  localparam logic signed [63:0] W40_LIM = 64'sd549755813887;
  localparam logic signed [63:0] W32_LIM = 64'sd2147483647;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
    logic [63:0]        lim;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
    logic [63:0]        raw;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic               sincos;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [63:0] ang;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] z;
    logic signed [63:0] s;
    logic signed [63:0] c;
  } cordic_rsp_t;

  function automatic logic signed [63:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [63:0] v;
    case (int'(i))
      0: v = 64'sd843314857;
      1: v = 64'sd497837829;
      2: v = 64'sd263043837;
      3: v = 64'sd133525159;
      4: v = 64'sd67021687;
      5: v = 64'sd33543516;
      6: v = 64'sd16775851;
      7: v = 64'sd8388437;
      8: v = 64'sd4194283;
      9: v = 64'sd2097149;
      default: v = (int'(i) <= 30) ? (64'sd1 <<< (30 - int'(i))) : 64'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    logic signed [63:0] r;
    if (v > lim) r = lim;
    else if (v < -lim - 64'sd1) r = -lim - 64'sd1;
    else r = v;
    return r;
  endfunction

endpackage

// ===== design/apes_mul.sv =====
// shared rounding, saturating multiplier built from 32x32 partial products
`timescale 1ns / 1ps

module apes_mul (
  input  logic              clk,
  input  logic              rst,
  input  apes_pkg::mul_req_t req,
  output apes_pkg::mul_rsp_t rsp
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_PP   = 3'd1;
  localparam logic [2:0] M_RND  = 3'd2;
  localparam logic [2:0] M_SHF  = 3'd3;
  localparam logic [2:0] M_SAT  = 3'd4;

  logic [2:0]   state;
  logic [1:0]   cnt;
  logic         done;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [5:0]   sh;
  logic [63:0]  lim;
  logic [127:0] prod;
  logic signed [63:0] result;
  logic [63:0]  raw;

  logic [31:0]  ah;
  logic [31:0]  bh;
  logic [63:0]  pp;
  logic [127:0] placed;
  logic [127:0] half;
  logic [63:0]  mag_c;
  logic [63:0]  cap;
  logic [63:0]  mag_s;

  always_comb begin
    ah = cnt[1] ? ua[63:32] : ua[31:0];
    bh = cnt[0] ? ub[63:32] : ub[31:0];
    pp = {32'b0, ah} * {32'b0, bh};
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0: placed = {64'b0, pp};
      2'd1: placed = {32'b0, pp, 32'b0};
      2'd2: placed = {pp, 64'b0};
      default: placed = '0;
    endcase
    half = (sh == 6'd0) ? 128'd0 : (128'd1 << (sh - 6'd1));
    mag_c = (|prod[127:64]) ? '1 : prod[63:0];
    cap = neg ? lim + 64'd1 : lim;
    mag_s = (mag_c > cap) ? cap : mag_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            state <= M_PP;
            cnt <= 2'd0;
          end
        end
        M_PP: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) state <= M_RND;
        end
        M_RND: state <= M_SHF;
        M_SHF: state <= M_SAT;
        M_SAT: begin
          state <= M_IDLE;
          done <= 1'b1;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE && req.start) begin
      ua <= req.a[63] ? 64'd0 - req.a : req.a;
      ub <= req.b[63] ? 64'd0 - req.b : req.b;
      neg <= req.a[63] ^ req.b[63];
      sh <= req.sh;
      lim <= req.lim;
      prod <= '0;
    end else if (state == M_PP) begin
      prod <= prod + placed;
    end else if (state == M_RND) begin
      prod <= prod + half;
    end else if (state == M_SHF) begin
      prod <= prod >> sh;
    end else if (state == M_SAT) begin
      raw <= prod[63:0];
      result <= neg ? $signed(64'd0 - mag_s) : $signed(mag_s);
    end
  end

  assign rsp.done = done;
  assign rsp.result = result;
  assign rsp.raw = raw;

endmodule

// ===== design/apes_cordic.sv =====
// iterative cordic for atan2 (vectoring) and sin/cos (rotation)
`timescale 1ns / 1ps

module apes_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  apes_pkg::cordic_req_t req,
  output apes_pkg::cordic_rsp_t rsp
);

  localparam logic [apes_pkg::ITER_W-1:0] LAST_ITER =
    apes_pkg::ITER_W'(apes_pkg::CORDIC_STEPS - 1);

  logic                       busy;
  logic                       done;
  logic [apes_pkg::ITER_W-1:0] iter;
  logic                       sincos;
  logic                       flip;
  logic signed [63:0]         x;
  logic signed [63:0]         y;
  logic signed [63:0]         z;

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [63:0] at;
  logic signed [63:0] x_next;
  logic signed [63:0] y_next;
  logic signed [63:0] z_next;
  logic signed [63:0] xs;
  logic signed [63:0] ys;
  logic               zero_in;

  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    at = apes_pkg::atan_q30(iter);
    if (sincos) begin
      if (z >= 0) begin
        x_next = x - dx;
        y_next = y + dy;
        z_next = z - at;
      end else begin
        x_next = x + dx;
        y_next = y - dy;
        z_next = z + at;
      end
    end else begin
      if (y >= 0) begin
        x_next = x + dx;
        y_next = y - dy;
        z_next = z + at;
      end else begin
        x_next = x - dx;
        y_next = y + dy;
        z_next = z - at;
      end
    end
    xs = 64'(req.x) <<< 20;
    ys = 64'(req.y) <<< 20;
    zero_in = (req.x == 32'sd0) && (req.y == 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        iter <= '0;
        if (!req.sincos && zero_in) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        iter <= iter + apes_pkg::ITER_W'(1);
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sincos <= req.sincos;
      if (req.sincos) begin
        x <= apes_pkg::GAIN_Q30;
        y <= 64'sd0;
        if (req.ang > apes_pkg::HALF_PI_Q30) begin
          z <= req.ang - apes_pkg::PI_Q30;
          flip <= 1'b1;
        end else if (req.ang < -apes_pkg::HALF_PI_Q30) begin
          z <= req.ang + apes_pkg::PI_Q30;
          flip <= 1'b1;
        end else begin
          z <= req.ang;
          flip <= 1'b0;
        end
      end else begin
        flip <= 1'b0;
        if (zero_in) begin
          x <= 64'sd0;
          y <= 64'sd0;
          z <= 64'sd0;
        end else if (xs < 0) begin
          if (ys >= 0) begin
            x <= ys;
            y <= -xs;
            z <= apes_pkg::HALF_PI_Q30;
          end else begin
            x <= -ys;
            y <= xs;
            z <= -apes_pkg::HALF_PI_Q30;
          end
        end else begin
          x <= xs;
          y <= ys;
          z <= 64'sd0;
        end
      end
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign rsp.done = done;
  assign rsp.z = z;
  assign rsp.s = flip ? -y : y;
  assign rsp.c = flip ? -x : x;

endmodule

// ===== design/aircraft_pitch_euler_step_core.sv =====
// top level: pitch-plane point-mass flight step with one shared multiplier
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready, field restart): one request is one tick.
// restart=1 reloads the initial flight state, restart=0 advances by one
// explicit Euler step. Output channel (out_valid/out_ready) returns one
// result per request: state after the update plus attack angle, lift, drag
// and the attack-range flag (these four are zero on a restart tick).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no request is in flight.
// A step request runs the cordic for atan2 of the velocity, then for sin/cos
// of that angle and of the roll angle, forms the attack angle and then does
// 29 multiplies in turn on the single multiplier; its result is then loaded
// into the output register, and the next request is accepted after that load.
// A restart skips the cordic and multiply work and goes straight to loading.
// One request is worked on at a time.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; the finished result then waits for the
// register to drain. Synchronous reset restores the configuration defaults
// and the initial flight state.

module aircraft_pitch_euler_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [47:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] pitch_rate,
  output logic signed [31:0] attack_angle,
  output logic signed [39:0] lift_force,
  output logic signed [39:0] drag_force,
  output logic        attack_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PB = apes_pkg::POSITION_BITS;
  localparam logic signed [63:0] POS_LIM = (64'sd1 <<< (PB - 1)) - 64'sd1;

  localparam logic signed [63:0] ALPHA_OFFSET = 64'sd9395241;
  localparam logic signed [63:0] CL_ELEV = 64'sd118111601;
  localparam logic signed [63:0] CD_ZERO = 64'sd4697620;
  localparam logic signed [63:0] CD_K = 64'sd14763950;
  localparam logic signed [63:0] CM_ZERO = -64'sd26843546;
  localparam logic signed [63:0] CM_ELEV = 64'sd391915766;
  localparam logic signed [63:0] CHORD_Q28 = 64'sd1771674010;
  localparam logic signed [63:0] INV_IY_Q60 = 64'sd118613323519;
  localparam logic signed [63:0] GRAVITY_Q16 = 64'sd642908;
  localparam logic signed [31:0] ALPHA_LOW = -32'sd71447509;
  localparam logic signed [31:0] ALPHA_HIGH = 32'sd84331486;
  localparam logic signed [63:0] Z0_Q16 = 64'sd720896000;
  localparam logic signed [31:0] VX0_Q16 = 32'sd18677760;
  localparam logic signed [31:0] PITCH0_Q28 = 32'sd7027624;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ATAN     = 3'd1;
  localparam logic [2:0] S_SC_GAMMA = 3'd2;
  localparam logic [2:0] S_SC_ROLL  = 3'd3;
  localparam logic [2:0] S_ALPHA    = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [4:0] OP_CL    = 5'd0;
  localparam logic [4:0] OP_CL2   = 5'd1;
  localparam logic [4:0] OP_CD    = 5'd2;
  localparam logic [4:0] OP_CM    = 5'd3;
  localparam logic [4:0] OP_SQX   = 5'd4;
  localparam logic [4:0] OP_SQY   = 5'd5;
  localparam logic [4:0] OP_SQZ   = 5'd6;
  localparam logic [4:0] OP_RHOA  = 5'd7;
  localparam logic [4:0] OP_QS    = 5'd8;
  localparam logic [4:0] OP_LIFT  = 5'd9;
  localparam logic [4:0] OP_DRAG  = 5'd10;
  localparam logic [4:0] OP_MQ    = 5'd11;
  localparam logic [4:0] OP_MOM   = 5'd12;
  localparam logic [4:0] OP_F     = 5'd13;
  localparam logic [4:0] OP_FX    = 5'd14;
  localparam logic [4:0] OP_AX    = 5'd15;
  localparam logic [4:0] OP_FY    = 5'd16;
  localparam logic [4:0] OP_AY    = 5'd17;
  localparam logic [4:0] OP_FZ    = 5'd18;
  localparam logic [4:0] OP_AZ    = 5'd19;
  localparam logic [4:0] OP_VX    = 5'd20;
  localparam logic [4:0] OP_VY    = 5'd21;
  localparam logic [4:0] OP_VZ    = 5'd22;
  localparam logic [4:0] OP_PX    = 5'd23;
  localparam logic [4:0] OP_PY    = 5'd24;
  localparam logic [4:0] OP_PZ    = 5'd25;
  localparam logic [4:0] OP_PACC  = 5'd26;
  localparam logic [4:0] OP_RATE  = 5'd27;
  localparam logic [4:0] OP_PITCH = 5'd28;

  // configuration
  logic [15:0]        step_time;
  logic [31:0]        mass_reciprocal;
  logic [16:0]        air_rho;
  logic [23:0]        wing_area;
  logic signed [31:0] elevator_deflection;
  logic signed [30:0] roll_angle;

  // flight state
  logic signed [PB-1:0] position_x;
  logic signed [PB-1:0] position_y;
  logic signed [PB-1:0] position_z;
  logic signed [31:0]   velocity_x;
  logic signed [31:0]   velocity_y;
  logic signed [31:0]   velocity_z;
  logic signed [31:0]   pitch_state;
  logic signed [31:0]   pitch_rate_state;

  // per-tick values
  logic [2:0]         state;
  logic [4:0]         op;
  logic               mul_start;
  logic               cord_start;
  logic               cord_sincos;
  logic signed [63:0] cord_ang;
  logic signed [63:0] g30;
  logic signed [63:0] sg;
  logic signed [63:0] cg;
  logic signed [63:0] sr;
  logic signed [63:0] cr;
  logic signed [31:0] alpha;
  logic               oor;
  logic signed [40:0] cl;
  logic signed [40:0] cl2;
  logic signed [41:0] cd;
  logic signed [40:0] cm;
  logic [63:0]        sq;
  logic [47:0]        v2;
  logic [40:0]        rhoa;
  logic signed [63:0] qs;
  logic signed [39:0] lift;
  logic signed [39:0] drag;
  logic signed [63:0] mom;
  logic signed [63:0] f;
  logic signed [63:0] tmp;
  logic signed [63:0] ax;
  logic signed [63:0] ay;
  logic signed [63:0] az;

  apes_pkg::mul_req_t    mul_req;
  apes_pkg::mul_rsp_t    mul_rsp;
  apes_pkg::cordic_req_t cord_req;
  apes_pkg::cordic_rsp_t cord_rsp;

  logic signed [63:0] a0;
  logic signed [63:0] gamma;
  logic signed [63:0] alpha_sat;
  logic signed [63:0] r;
  logic signed [63:0] dt64;
  logic [63:0]        sq_sum;
  logic signed [63:0] px64;
  logic signed [63:0] py64;
  logic signed [63:0] pz64;
  logic               out_load;

  function automatic logic signed [63:0] mag32(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return (w < 0) ? -w : w;
  endfunction

  apes_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  apes_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  assign cord_req.start = cord_start;
  assign cord_req.sincos = cord_sincos;
  assign cord_req.x = velocity_x;
  assign cord_req.y = velocity_z;
  assign cord_req.ang = cord_ang;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    a0 = 64'(alpha) + ALPHA_OFFSET;
    gamma = (g30 + 64'sd2) >>> 2;
    alpha_sat = apes_pkg::sat64(64'(pitch_state) - gamma, apes_pkg::W32_LIM);
    r = mul_rsp.result;
    dt64 = 64'(step_time);
    sq_sum = sq + mul_rsp.raw + 64'd32768;
    px64 = 64'(position_x);
    py64 = 64'(position_y);
    pz64 = 64'(position_z);
  end

  always_comb begin
    mul_req.start = mul_start;
    mul_req.a = 64'sd0;
    mul_req.b = 64'sd0;
    mul_req.sh = 6'd0;
    mul_req.lim = apes_pkg::BIG_LIM;
    unique case (op)
      OP_CL: begin
        mul_req.a = CL_ELEV; mul_req.b = 64'(elevator_deflection); mul_req.sh = 6'd28;
      end
      OP_CL2: begin
        mul_req.a = 64'(cl); mul_req.b = 64'(cl); mul_req.sh = 6'd28;
        mul_req.lim = apes_pkg::COEF_LIM;
      end
      OP_CD: begin
        mul_req.a = CD_K; mul_req.b = 64'(cl2); mul_req.sh = 6'd28;
        mul_req.lim = apes_pkg::COEF_LIM;
      end
      OP_CM: begin
        mul_req.a = CM_ELEV; mul_req.b = 64'(elevator_deflection); mul_req.sh = 6'd28;
      end
      OP_SQX: begin
        mul_req.a = mag32(velocity_x); mul_req.b = mag32(velocity_x);
      end
      OP_SQY: begin
        mul_req.a = mag32(velocity_y); mul_req.b = mag32(velocity_y);
      end
      OP_SQZ: begin
        mul_req.a = mag32(velocity_z); mul_req.b = mag32(velocity_z);
      end
      OP_RHOA: begin
        mul_req.a = {47'd0, air_rho}; mul_req.b = {40'd0, wing_area};
      end
      OP_QS: begin
        mul_req.a = {23'd0, rhoa}; mul_req.b = {16'd0, v2}; mul_req.sh = 6'd33;
      end
      OP_LIFT: begin
        mul_req.a = qs; mul_req.b = 64'(cl); mul_req.sh = 6'd28;
        mul_req.lim = apes_pkg::W40_LIM;
      end
      OP_DRAG: begin
        mul_req.a = qs; mul_req.b = 64'(cd); mul_req.sh = 6'd28;
        mul_req.lim = apes_pkg::W40_LIM;
      end
      OP_MQ: begin
        mul_req.a = qs; mul_req.b = 64'(cm); mul_req.sh = 6'd28;
      end
      OP_MOM: begin
        mul_req.a = tmp; mul_req.b = CHORD_Q28; mul_req.sh = 6'd28;
      end
      OP_F: begin
        mul_req.a = 64'(lift); mul_req.b = sg; mul_req.sh = 6'd30;
      end
      OP_FX: begin
        mul_req.a = f; mul_req.b = cr; mul_req.sh = 6'd30;
      end
      OP_AX, OP_AY, OP_AZ: begin
        mul_req.a = tmp; mul_req.b = {32'd0, mass_reciprocal}; mul_req.sh = 6'd32;
      end
      OP_FY: begin
        mul_req.a = f; mul_req.b = sr; mul_req.sh = 6'd30;
      end
      OP_FZ: begin
        mul_req.a = 64'(lift); mul_req.b = cg; mul_req.sh = 6'd30;
      end
      OP_VX: begin
        mul_req.a = ax; mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_VY: begin
        mul_req.a = ay; mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_VZ: begin
        mul_req.a = az; mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_PX: begin
        mul_req.a = 64'(velocity_x); mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_PY: begin
        mul_req.a = 64'(velocity_y); mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_PZ: begin
        mul_req.a = 64'(velocity_z); mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_PACC: begin
        mul_req.a = mom; mul_req.b = INV_IY_Q60; mul_req.sh = 6'd40;
      end
      OP_RATE: begin
        mul_req.a = tmp; mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      OP_PITCH: begin
        mul_req.a = 64'(pitch_rate_state); mul_req.b = dt64; mul_req.sh = 6'd16;
      end
      default: begin
        mul_req.a = 64'sd0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 16'd6554;
      mass_reciprocal <= 32'd7843670;
      air_rho <= 17'd23849;
      wing_area <= 24'd92570;
      elevator_deflection <= -32'sd29634737;
      roll_angle <= 31'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apes_pkg::REG_STEP_TIME:  step_time <= cfg_data[15:0];
        apes_pkg::REG_MASS_RECIP: mass_reciprocal <= cfg_data;
        apes_pkg::REG_DENSITY:    air_rho <= cfg_data[16:0];
        apes_pkg::REG_WING_AREA:  wing_area <= cfg_data[23:0];
        apes_pkg::REG_ELEVATOR:   elevator_deflection <= $signed(cfg_data);
        apes_pkg::REG_ROLL:       roll_angle <= $signed(cfg_data[30:0]);
        // yaw only scales thrust minus drag, which is zero
        apes_pkg::REG_YAW:        step_time <= step_time;
        default:                  step_time <= step_time;
      endcase
    end
  end

  // sequencer and flight state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_CL;
      mul_start <= 1'b0;
      cord_start <= 1'b0;
      cord_sincos <= 1'b0;
      position_x <= '0;
      position_y <= '0;
      position_z <= PB'(Z0_Q16);
      velocity_x <= VX0_Q16;
      velocity_y <= 32'sd0;
      velocity_z <= 32'sd0;
      pitch_state <= PITCH0_Q28;
      pitch_rate_state <= 32'sd0;
      alpha <= 32'sd0;
      oor <= 1'b0;
      lift <= 40'sd0;
      drag <= 40'sd0;
    end else begin
      mul_start <= 1'b0;
      cord_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              position_x <= '0;
              position_y <= '0;
              position_z <= PB'(Z0_Q16);
              velocity_x <= VX0_Q16;
              velocity_y <= 32'sd0;
              velocity_z <= 32'sd0;
              pitch_state <= PITCH0_Q28;
              pitch_rate_state <= 32'sd0;
              alpha <= 32'sd0;
              oor <= 1'b0;
              lift <= 40'sd0;
              drag <= 40'sd0;
              state <= S_DONE;
            end else begin
              cord_sincos <= 1'b0;
              cord_start <= 1'b1;
              state <= S_ATAN;
            end
          end
        end
        S_ATAN: begin
          if (cord_rsp.done) begin
            g30 <= cord_rsp.z;
            cord_ang <= cord_rsp.z;
            cord_sincos <= 1'b1;
            cord_start <= 1'b1;
            state <= S_SC_GAMMA;
          end
        end
        S_SC_GAMMA: begin
          if (cord_rsp.done) begin
            sg <= cord_rsp.s;
            cg <= cord_rsp.c;
            cord_ang <= 64'(roll_angle) <<< 2;
            cord_start <= 1'b1;
            state <= S_SC_ROLL;
          end
        end
        S_SC_ROLL: begin
          if (cord_rsp.done) begin
            sr <= cord_rsp.s;
            cr <= cord_rsp.c;
            state <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          alpha <= alpha_sat[31:0];
          oor <= (alpha_sat < 64'(ALPHA_LOW)) || (alpha_sat > 64'(ALPHA_HIGH));
          op <= OP_CL;
          mul_start <= 1'b1;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            unique case (op)
              OP_CL:   cl <= 41'(apes_pkg::sat64((a0 <<< 2) + a0 + r, apes_pkg::COEF_LIM));
              OP_CL2:  cl2 <= r[40:0];
              OP_CD:   cd <= 42'(CD_ZERO + r);
              OP_CM:   cm <= 41'(apes_pkg::sat64(CM_ZERO - a0 - r, apes_pkg::COEF_LIM));
              OP_SQX:  sq <= mul_rsp.raw;
              OP_SQY:  sq <= sq + mul_rsp.raw;
              OP_SQZ:  v2 <= sq_sum[63:16];
              OP_RHOA: rhoa <= mul_rsp.raw[40:0];
              OP_QS:   qs <= r;
              OP_LIFT: lift <= r[39:0];
              OP_DRAG: drag <= r[39:0];
              OP_MQ:   tmp <= r;
              OP_MOM:  mom <= r;
              OP_F:    f <= r;
              OP_FX:   tmp <= r;
              OP_AX:   ax <= -r;
              OP_FY:   tmp <= r;
              OP_AY:   ay <= r;
              OP_FZ:   tmp <= r;
              OP_AZ:   az <= r - GRAVITY_Q16;
              OP_VX:   velocity_x <= 32'(apes_pkg::sat64(64'(velocity_x) + r,
                                                         apes_pkg::W32_LIM));
              OP_VY:   velocity_y <= 32'(apes_pkg::sat64(64'(velocity_y) + r,
                                                         apes_pkg::W32_LIM));
              OP_VZ:   velocity_z <= 32'(apes_pkg::sat64(64'(velocity_z) + r,
                                                         apes_pkg::W32_LIM));
              OP_PX:   position_x <= PB'(apes_pkg::sat64(px64 + r, POS_LIM));
              OP_PY:   position_y <= PB'(apes_pkg::sat64(py64 + r, POS_LIM));
              OP_PZ:   position_z <= PB'(apes_pkg::sat64(pz64 + r, POS_LIM));
              OP_PACC: tmp <= r;
              OP_RATE: pitch_rate_state <= 32'(apes_pkg::sat64(64'(pitch_rate_state) + r,
                                                               apes_pkg::W32_LIM));
              OP_PITCH: pitch_state <= 32'(apes_pkg::sat64(64'(pitch_state) + r,
                                                           apes_pkg::W32_LIM));
              default: tmp <= r;
            endcase
            if (op == OP_PITCH) begin
              state <= S_DONE;
            end else begin
              op <= op + 5'd1;
              mul_start <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x <= px64[47:0];
      pos_y <= py64[47:0];
      pos_z <= pz64[47:0];
      vel_x <= velocity_x;
      vel_y <= velocity_y;
      vel_z <= velocity_z;
      pitch_angle <= pitch_state;
      pitch_rate <= pitch_rate_state;
      attack_angle <= alpha;
      lift_force <= lift;
      drag_force <= drag;
      attack_out_of_range <= oor;
    end
  end

`ifndef SYNTHESIS
  a_mul_start_in_seq: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (state == S_MUL))
    else $error("multiply started outside the multiply sequence");

  a_cordic_done_state: assert property (@(posedge clk) disable iff (rst)
    cord_rsp.done |-> (state == S_ATAN || state == S_SC_GAMMA || state == S_SC_ROLL))
    else $error("cordic finished while not awaited");

  a_op_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (op <= OP_PITCH))
    else $error("multiply step out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule
